/* hw/rtl/wbm_pkg.sv */
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared constants, types and helpers for the WAH bitmap merge block.
// ----------------------------------------------------------------------------
package wbm_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int WORD_W      = 8;
    localparam int SPAN_W      = 7;
    localparam int FILL_BIT    = 7;
    localparam int CMD_W       = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CMD_W-1:0] CMD_LOAD_X = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_Y = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PULL   = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD_X,
        K_LOAD_Y,
        K_PULL,
        K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_EXEC
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [WORD_W-1:0]  word;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]  out_word;
        logic               last;
        logic               overflow;
    } t_rsp;

    typedef struct packed {
        logic merging;
        logic x_fin;
        logic y_fin;
    } t_eng_status;

    // groups covered by one word; a zero-count fill covers one
    function automatic logic [SPAN_W-1:0] span_of(input logic [WORD_W-1:0] w);
        logic [SPAN_W-1:0] s;
        s = SPAN_W'(1);
        if (w[FILL_BIT] && (w[SPAN_W-1:0] != '0)) begin
            s = w[SPAN_W-1:0];
        end
        return s;
    endfunction

    // literal bits of a word; fills read as zero
    function automatic logic [SPAN_W-1:0] lit_val(input logic [WORD_W-1:0] w);
        return w[FILL_BIT] ? '0 : w[SPAN_W-1:0];
    endfunction

endpackage

/* hw/rtl/wbm_if.sv */
// ----------------------------------------------------------------------------
// wbm_if
// Valid/ready channels of the WAH bitmap merge block: command in, word out.
// ----------------------------------------------------------------------------
interface wbm_in_if import wbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] word;

    modport source (output valid, cmd, word, input ready);
    modport sink   (input valid, cmd, word, output ready);
endinterface

interface wbm_out_if import wbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              last;
    logic              overflow;

    modport source (output valid, out_word, last, overflow, input ready);
    modport sink   (input valid, out_word, last, overflow, output ready);
endinterface

/* hw/rtl/wbm_front.sv */
// ----------------------------------------------------------------------------
// wbm_front
// Accepts command requests, decodes them and queues them for the engine.
// ----------------------------------------------------------------------------
module wbm_front import wbm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wbm_in_if.sink       i_in,
    input  logic         i_pop,
    output logic         o_head_valid,
    output t_req         o_head
);

    t_req              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    logic              pop;
    t_req              req;

    always_comb begin
        req.word = i_in.word;
        case (i_in.cmd)
            CMD_LOAD_X: req.kind = K_LOAD_X;
            CMD_LOAD_Y: req.kind = K_LOAD_Y;
            CMD_PULL:   req.kind = K_PULL;
            default:    req.kind = K_NOP;
        endcase
    end

    assign i_in.ready   = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_cnt    = r_cnt + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= req;
        end
    end

endmodule

/* hw/rtl/wbm_back.sv */
// ----------------------------------------------------------------------------
// wbm_back
// Merge engine: word stores, operand cursors and the output register.
// ----------------------------------------------------------------------------
module wbm_back import wbm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_mode,
    input  logic         i_head_valid,
    input  t_req         i_head,
    output logic         o_pop,
    wbm_out_if.source    o_out,
    output t_eng_status  o_status
);

    logic [WORD_W-1:0] x_mem [STORE_DEPTH];
    logic [WORD_W-1:0] y_mem [STORE_DEPTH];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_x_cnt, n_x_cnt, r_y_cnt, n_y_cnt;
    logic [CNT_W-1:0]  r_x_pos, n_x_pos, r_y_pos, n_y_pos;
    logic [SPAN_W-1:0] r_x_span, n_x_span, r_y_span, n_y_span;
    logic              r_x_fin, n_x_fin, r_y_fin, n_y_fin;
    logic              r_merging, n_merging;
    logic              r_dropped, n_dropped;
    logic [WORD_W-1:0] r_x_word, n_x_word, r_y_word, n_y_word;
    logic [WORD_W-1:0] r_x_rd, r_y_rd;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    logic              x_we, y_we, rd_en, slot_free;
    logic [ADDR_W-1:0] x_rd_addr, y_rd_addr;
    logic [CNT_W-1:0]  x_pos_inc, y_pos_inc, x_len, y_len;
    logic [WORD_W-1:0] x_cur, y_cur, x_w0, y_w0;
    logic [SPAN_W-1:0] run, xs, ys, vx, vy;
    logic              xf, yf, last;

    assign slot_free = !r_out_valid || o_out.ready;
    assign x_pos_inc = r_x_pos + CNT_W'(1);
    assign y_pos_inc = r_y_pos + CNT_W'(1);
    assign x_len     = (r_x_cnt == '0) ? CNT_W'(1) : r_x_cnt;
    assign y_len     = (r_y_cnt == '0) ? CNT_W'(1) : r_y_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid && (i_head.kind == K_PULL)) begin
                    n_state = r_merging ? S_EXEC : S_INIT;
                end
            end
            S_INIT: n_state = S_EXEC;
            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_x_cnt     = r_x_cnt;
        n_y_cnt     = r_y_cnt;
        n_x_pos     = r_x_pos;
        n_y_pos     = r_y_pos;
        n_x_span    = r_x_span;
        n_y_span    = r_y_span;
        n_x_fin     = r_x_fin;
        n_y_fin     = r_y_fin;
        n_merging   = r_merging;
        n_dropped   = r_dropped;
        n_x_word    = r_x_word;
        n_y_word    = r_y_word;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        x_we        = 1'b0;
        y_we        = 1'b0;
        rd_en       = 1'b0;
        o_pop       = 1'b0;
        x_rd_addr   = x_pos_inc[ADDR_W-1:0];
        y_rd_addr   = y_pos_inc[ADDR_W-1:0];
        x_w0        = (r_x_cnt == '0) ? '0 : r_x_rd;
        y_w0        = (r_y_cnt == '0) ? '0 : r_y_rd;
        x_cur       = r_x_fin ? '0 : r_x_word;
        y_cur       = r_y_fin ? '0 : r_y_word;
        run         = (r_x_span < r_y_span) ? r_x_span : r_y_span;
        vx          = lit_val(x_cur);
        vy          = lit_val(y_cur);
        xs          = r_x_span - run;
        ys          = r_y_span - run;
        xf          = r_x_fin;
        yf          = r_y_fin;
        last        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    case (i_head.kind)
                        K_LOAD_X: begin
                            o_pop = 1'b1;
                            if (r_merging || (r_x_cnt == CNT_W'(STORE_DEPTH))) begin
                                n_dropped = 1'b1;
                            end else begin
                                x_we    = 1'b1;
                                n_x_cnt = r_x_cnt + CNT_W'(1);
                            end
                        end
                        K_LOAD_Y: begin
                            o_pop = 1'b1;
                            if (r_merging || (r_y_cnt == CNT_W'(STORE_DEPTH))) begin
                                n_dropped = 1'b1;
                            end else begin
                                y_we    = 1'b1;
                                n_y_cnt = r_y_cnt + CNT_W'(1);
                            end
                        end
                        K_PULL: begin
                            rd_en = 1'b1;
                            if (!r_merging) begin
                                x_rd_addr = '0;
                                y_rd_addr = '0;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_INIT: begin
                n_x_word  = x_w0;
                n_y_word  = y_w0;
                n_x_span  = span_of(x_w0);
                n_y_span  = span_of(y_w0);
                n_x_pos   = '0;
                n_y_pos   = '0;
                n_x_fin   = 1'b0;
                n_y_fin   = 1'b0;
                n_merging = 1'b1;
                rd_en     = 1'b1;
                x_rd_addr = ADDR_W'(1);
                y_rd_addr = ADDR_W'(1);
            end
            S_EXEC: begin
                if (slot_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    if (run > SPAN_W'(1)) begin
                        n_out.out_word = {1'b1, run};
                    end else begin
                        n_out.out_word = {1'b0, i_op_mode ? (vx & ~vy) : (vx | vy)};
                    end
                    if ((xs == '0) && !r_x_fin) begin
                        n_x_pos = x_pos_inc;
                        if (x_pos_inc >= x_len) begin
                            xf = 1'b1;
                        end else begin
                            xs       = span_of(r_x_rd);
                            n_x_word = r_x_rd;
                        end
                    end
                    if ((ys == '0) && !r_y_fin) begin
                        n_y_pos = y_pos_inc;
                        if (y_pos_inc >= y_len) begin
                            yf = 1'b1;
                        end else begin
                            ys       = span_of(r_y_rd);
                            n_y_word = r_y_rd;
                        end
                    end
                    if (xf && yf) begin
                        last = 1'b1;
                    end else if (xf) begin
                        xs = ys;
                    end else if (yf) begin
                        ys = xs;
                    end
                    n_out.last     = last;
                    n_out.overflow = r_dropped;
                    n_x_span       = xs;
                    n_y_span       = ys;
                    n_x_fin        = xf;
                    n_y_fin        = yf;
                    if (last) begin
                        n_x_cnt   = '0;
                        n_y_cnt   = '0;
                        n_x_pos   = '0;
                        n_y_pos   = '0;
                        n_x_span  = '0;
                        n_y_span  = '0;
                        n_x_fin   = 1'b0;
                        n_y_fin   = 1'b0;
                        n_merging = 1'b0;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x_cnt     <= '0;
            r_y_cnt     <= '0;
            r_x_pos     <= '0;
            r_y_pos     <= '0;
            r_x_span    <= '0;
            r_y_span    <= '0;
            r_x_fin     <= 1'b0;
            r_y_fin     <= 1'b0;
            r_merging   <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x_cnt     <= n_x_cnt;
            r_y_cnt     <= n_y_cnt;
            r_x_pos     <= n_x_pos;
            r_y_pos     <= n_y_pos;
            r_x_span    <= n_x_span;
            r_y_span    <= n_y_span;
            r_x_fin     <= n_x_fin;
            r_y_fin     <= n_y_fin;
            r_merging   <= n_merging;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_word <= n_x_word;
        r_y_word <= n_y_word;
        r_out    <= n_out;
    end

    // X store
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            x_mem[r_x_cnt[ADDR_W-1:0]] <= i_head.word;
        end
        if (rd_en) begin
            r_x_rd <= x_mem[x_rd_addr];
        end
    end

    // Y store
    always_ff @(posedge i_clk) begin
        if (y_we) begin
            y_mem[r_y_cnt[ADDR_W-1:0]] <= i_head.word;
        end
        if (rd_en) begin
            r_y_rd <= y_mem[y_rd_addr];
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_word = r_out.out_word;
    assign o_out.last     = r_out.last;
    assign o_out.overflow = r_out.overflow;

    assign o_status.merging = r_merging;
    assign o_status.x_fin   = r_x_fin;
    assign o_status.y_fin   = r_y_fin;

endmodule

/* hw/rtl/wah_bitmap_merge.sv */
// ----------------------------------------------------------------------------
// wah_bitmap_merge
// OR / AND-NOT merge of two 8-bit word-aligned-hybrid compressed bitmaps.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries command requests: load a word into X, load a word into Y,
//   or pull the next merged word. o_out returns one word per pull with
//   the merged word, a last flag and a dropped-load flag.
//   i_cfg_we / i_cfg_wdata write op_mode (0: X OR Y, 1: X AND NOT Y) while
//   the block is idle.
// Timing:
//   Commands enter a two-entry queue; the engine drains it. A pull reads the
//   next words from the stores, then runs the merge step; the first pull of
//   a merge first fetches both head words. Each store has one read port.
//   The merge step writes the result into the output register.
// Reset:
//   Clears word counts, cursors, flags, queue and op_mode. Store contents are
//   left as they are; only entries below the count are used.
// Stalls:
//   A held result blocks the next merge step; the queue keeps taking
//   commands until it is full, then ready drops.
// ----------------------------------------------------------------------------
module wah_bitmap_merge import wbm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    wbm_in_if.sink     i_in,
    wbm_out_if.source  o_out
);

    logic        r_op_mode;
    logic        head_valid;
    t_req        head;
    logic        pop;
    t_eng_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_op_mode <= i_cfg_wdata;
        end
    end

    wbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    wbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_mode    (r_op_mode),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out),
        .o_status     (status)
    );

`ifndef NO_ASSERTIONS
    a_end_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(status.merging) && $past(i_rst_n) |-> o_out.valid && o_out.last)
        else $error("merge ended without a last word");

    a_not_both_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.merging |-> !(status.x_fin && status.y_fin))
        else $error("merge still open with both operands finished");

    a_fill_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_word[FILL_BIT] |-> o_out.out_word[SPAN_W-1:1] != '0)
        else $error("fill word with span below two");
`endif

endmodule
